// ----- src/sdm_pkg.sv -----
package sdm_pkg;

   // sample and register field widths
   localparam int SAMPLE_BITS = 24;
   localparam int LATENCY_W   = 15;
   localparam int INTERVAL_W  = 18;
   localparam int LEVEL_W     = 23;
   localparam int MIX_W       = 13;
   localparam int GAIN_W      = 16;

   // register write port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   localparam logic [CSR_INDEX_W-1:0] REG_LATENCY     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PING_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PING_INTVL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PING_LEVEL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIX_AMOUNT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT_GAIN  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_GAIN = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_BYPASS      = 3'd7;

   // reset values
   localparam logic [LATENCY_W-1:0]  RST_LATENCY  = 15'd480;
   localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 18'd48000;
   localparam logic [LEVEL_W-1:0]    RST_LEVEL    = 23'd2107175;
   localparam logic [MIX_W-1:0]      RST_MIX      = 13'd4096;
   localparam logic [GAIN_W-1:0]     RST_GAIN     = 16'd4096;

   // Q1.12 mix constants
   localparam logic [MIX_W-1:0] Q12_ONE      = 13'd4096;
   localparam logic [MIX_W-1:0] MIX_WET_ONLY = 13'd4092;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_item_type;

   // settings and per-item control shared by both lanes
   typedef struct packed {
      logic [GAIN_W-1:0]  input_gain;
      logic [GAIN_W-1:0]  output_gain;
      logic [MIX_W-1:0]   mix_amount;
      logic [LEVEL_W-1:0] ping;
      logic               bypass;
      logic               lat_zero;
      logic               hist_valid;
   } lane_cfg_type;

   // stage enables from the sequencer
   typedef struct packed {
      logic load;
      logic prod;
      logic sum;
      logic mulmix;
      logic mix;
      logic mulout;
   } lane_step_type;

endpackage

// ----- src/sdm_ctrl.sv -----
module sdm_ctrl #(
   parameter int DELAY_DEPTH = 32768,
   localparam int POS_W = $clog2(DELAY_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [sdm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sdm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              advance,
   output sdm_pkg::lane_cfg_type             cfg,
   output logic [POS_W-1:0]                  wr_pos,
   output logic [POS_W-1:0]                  rd_pos
);
   import sdm_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(DELAY_DEPTH - 1);

   logic [LATENCY_W-1:0]  latency_ff;
   logic                  ping_en_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [MIX_W-1:0]      mix_ff;
   logic [GAIN_W-1:0]     in_gain_ff;
   logic [GAIN_W-1:0]     out_gain_ff;
   logic                  bypass_ff;
   logic [POS_W-1:0]      wp_ff;
   logic                  full_ff;
   logic [INTERVAL_W-1:0] cd_ff;

   logic [INTERVAL_W-1:0] eff_interval;
   logic [INTERVAL_W-1:0] new_interval;
   logic [INTERVAL_W-1:0] cd_in;
   logic [POS_W-1:0]      lat_eff;
   logic [POS_W:0]        wrap_pos;
   logic                  lat_zero;

   assign eff_interval = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
   assign new_interval = (csr_wdata[INTERVAL_W-1:0] == '0) ? INTERVAL_W'(1)
                                                         : csr_wdata[INTERVAL_W-1:0];

   // a latency setting at or above DELAY_DEPTH saturates to LAST_POS, the last store position
   assign lat_eff  = (32'(latency_ff) >= 32'(DELAY_DEPTH)) ? LAST_POS : POS_W'(latency_ff);
   assign lat_zero = (latency_ff == '0);
   assign wrap_pos = (POS_W+1)'(wp_ff) + (POS_W+1)'(DELAY_DEPTH) - (POS_W+1)'(lat_eff);

   assign wr_pos = wp_ff;
   assign rd_pos = (wp_ff >= lat_eff) ? (wp_ff - lat_eff) : wrap_pos[POS_W-1:0];

   // countdown step for one processed item
   always_comb begin
      if (ping_en_ff) begin
         cd_in = (cd_ff == '0) ? (eff_interval - INTERVAL_W'(1)) : (cd_ff - INTERVAL_W'(1));
      end else begin
         cd_in = eff_interval;
      end
   end

   always_comb begin
      cfg.input_gain  = in_gain_ff;
      cfg.output_gain = out_gain_ff;
      cfg.mix_amount  = mix_ff;
      cfg.ping        = (ping_en_ff && cd_ff == '0) ? level_ff : '0;
      cfg.bypass      = bypass_ff;
      cfg.lat_zero    = lat_zero;
      // entries are written in order from zero after a clear
      cfg.hist_valid  = full_ff || (wp_ff >= lat_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latency_ff  <= RST_LATENCY;
         ping_en_ff  <= 1'b0;
         interval_ff <= RST_INTERVAL;
         level_ff    <= RST_LEVEL;
         mix_ff      <= RST_MIX;
         in_gain_ff  <= RST_GAIN;
         out_gain_ff <= RST_GAIN;
         bypass_ff   <= 1'b0;
         wp_ff       <= '0;
         full_ff     <= 1'b0;
         cd_ff       <= RST_INTERVAL;
      end else if (csr_write) begin
         case (csr_index)
            REG_LATENCY: begin
               latency_ff <= csr_wdata[LATENCY_W-1:0];
               wp_ff      <= '0;
               full_ff    <= 1'b0;
            end
            REG_PING_ENABLE: ping_en_ff <= csr_wdata[0];
            REG_PING_INTVL: begin
               interval_ff <= csr_wdata[INTERVAL_W-1:0];
               if (cd_ff > new_interval) begin
                  cd_ff <= new_interval;
               end
            end
            REG_PING_LEVEL:  level_ff    <= csr_wdata[LEVEL_W-1:0];
            REG_MIX_AMOUNT:  mix_ff      <= csr_wdata[MIX_W-1:0];
            REG_INPUT_GAIN:  in_gain_ff  <= csr_wdata[GAIN_W-1:0];
            REG_OUTPUT_GAIN: out_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_BYPASS:      bypass_ff   <= csr_wdata[0];
            default: ;
         endcase
      end else if (advance && !bypass_ff) begin
         cd_ff <= cd_in;
         if (!lat_zero) begin
            if (wp_ff == LAST_POS) begin
               wp_ff   <= '0;
               full_ff <= 1'b1;
            end else begin
               wp_ff <= wp_ff + POS_W'(1);
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= LAST_POS)
      else $error("write position beyond delay store");

   a_cd_bound: assert property (@(posedge clock) disable iff (reset)
      cd_ff <= eff_interval)
      else $error("ping countdown above interval");

   a_lat_clear: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == REG_LATENCY) |=> (wp_ff == '0 && !full_ff))
      else $error("latency write did not clear history");
`endif

endmodule

// ----- src/sdm_lane.sv -----
module sdm_lane #(
   parameter int DELAY_DEPTH = 32768,
   localparam int POS_W = $clog2(DELAY_DEPTH)
) (
   input  logic                                    clock,
   input  sdm_pkg::lane_step_type                  step,
   input  sdm_pkg::lane_cfg_type                   cfg,
   input  logic [POS_W-1:0]                        wr_pos,
   input  logic [POS_W-1:0]                        rd_pos,
   input  logic signed [sdm_pkg::SAMPLE_BITS-1:0]  req_sample,
   output logic signed [sdm_pkg::SAMPLE_BITS-1:0]  rsp_sample
);
   import sdm_pkg::*;

   localparam int WORK_W     = 48;
   localparam int IN_PROD_W  = SAMPLE_BITS + GAIN_W + 1;
   localparam int MIX_PROD_W = SAMPLE_BITS + MIX_W + 1;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [WORK_W-1:0]      ROUND_HALF = 48'sd2048;

   // round(v / 4096), halves up
   function automatic logic signed [WORK_W-1:0] scale_q12(input logic signed [WORK_W-1:0] v);
      logic signed [WORK_W-1:0] t;
      t = v + ROUND_HALF;
      return t >>> 12;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [WORK_W-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > WORK_W'(S_MAX)) begin
         r = S_MAX;
      end else if (v < WORK_W'(S_MIN)) begin
         r = S_MIN;
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

   logic signed [SAMPLE_BITS-1:0] in_ff;
   logic signed [IN_PROD_W-1:0]   prod_ff;
   logic signed [SAMPLE_BITS-1:0] rd_ff;
   logic signed [SAMPLE_BITS-1:0] dry_ff;
   logic signed [SAMPLE_BITS-1:0] wet_ff;
   logic signed [MIX_PROD_W-1:0]  wet_prod_ff;
   logic signed [MIX_PROD_W-1:0]  dry_prod_ff;
   logic signed [SAMPLE_BITS-1:0] mix_ff;
   logic signed [IN_PROD_W-1:0]   out_prod_ff;

   logic signed [SAMPLE_BITS-1:0] dry_in;
   logic signed [SAMPLE_BITS-1:0] sum;
   logic signed [SAMPLE_BITS-1:0] wet_in;
   logic signed [SAMPLE_BITS-1:0] mix_in;
   logic [MIX_W-1:0]              dry_weight;
   logic                          mem_wr;

   assign dry_in = sat_sample(scale_q12(WORK_W'(prod_ff)));
   assign sum    = sat_sample(WORK_W'(dry_in) + WORK_W'($signed({1'b0, cfg.ping})));
   assign wet_in = cfg.lat_zero ? sum : (cfg.hist_valid ? rd_ff : '0);
   assign mem_wr = step.sum && !cfg.bypass && !cfg.lat_zero;

   assign dry_weight = Q12_ONE - cfg.mix_amount;
   assign mix_in = (cfg.mix_amount >= MIX_WET_ONLY) ? wet_ff
                 : sat_sample(scale_q12(WORK_W'(wet_prod_ff) + WORK_W'(dry_prod_ff)));

   assign rsp_sample = cfg.bypass ? in_ff : sat_sample(scale_q12(WORK_W'(out_prod_ff)));

   always_ff @(posedge clock) begin
      if (step.prod) begin
         rd_ff <= mem[rd_pos];
      end
      if (mem_wr) begin
         mem[wr_pos] <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (step.load) begin
         in_ff <= req_sample;
      end
      if (step.prod) begin
         prod_ff <= IN_PROD_W'(in_ff) * IN_PROD_W'($signed({1'b0, cfg.input_gain}));
      end
      if (step.sum) begin
         dry_ff <= dry_in;
         wet_ff <= wet_in;
      end
      if (step.mulmix) begin
         wet_prod_ff <= MIX_PROD_W'(wet_ff) * MIX_PROD_W'($signed({1'b0, cfg.mix_amount}));
         dry_prod_ff <= MIX_PROD_W'(dry_ff) * MIX_PROD_W'($signed({1'b0, dry_weight}));
      end
      if (step.mix) begin
         mix_ff <= mix_in;
      end
      if (step.mulout) begin
         out_prod_ff <= IN_PROD_W'(mix_ff) * IN_PROD_W'($signed({1'b0, cfg.output_gain}));
      end
   end

endmodule

// ----- src/stereo_delay_with_ping_and_mix_unit.sv -----
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_stall    req_data  (left_in, right_in)
// rsp      out        rsp_valid / rsp_stall    rsp_data  (left_out, right_out)
// csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
// Items are taken one at a time: the accept cycle, then the lane steps set by the
// three chained multiplies in each lane (input trim, mix, output trim) and the
// delay-store read ahead of the write. Both channels run in their own lane.
// Reset is synchronous; the delay history needs no clearing pass, a write
// count marks which entries hold data. csr_ready is always high.
// A finished item waits in the output register while the next one is taken in.
module stereo_delay_with_ping_and_mix_unit #(
   parameter int DELAY_DEPTH = 32768
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  sdm_pkg::req_item_type            req_data,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sdm_pkg::rsp_item_type            rsp_data,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sdm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sdm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sdm_pkg::*;

   localparam int POS_W = $clog2(DELAY_DEPTH);

   // item sequencer: one item in flight
   typedef enum logic [2:0] {
      S_IDLE,
      S_PROD,
      S_SUM,
      S_MULMIX,
      S_MIX,
      S_MULOUT,
      S_DONE
   } seq_state_type;

   seq_state_type  state_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_data_ff;

   lane_step_type  step;
   lane_cfg_type   cfg;
   logic [POS_W-1:0] wr_pos;
   logic [POS_W-1:0] rd_pos;
   logic signed [SAMPLE_BITS-1:0] left_res;
   logic signed [SAMPLE_BITS-1:0] right_res;
   logic           rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   // output register is empty or is taken this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      step.load   = req_valid && !req_stall;
      step.prod   = (state_ff == S_PROD);
      step.sum    = (state_ff == S_SUM);
      step.mulmix = (state_ff == S_MULMIX);
      step.mix    = (state_ff == S_MIX);
      step.mulout = (state_ff == S_MULOUT);
   end

   // settings, ping countdown and delay-store positions
   sdm_ctrl #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (step.sum),
      .cfg       (cfg),
      .wr_pos    (wr_pos),
      .rd_pos    (rd_pos)
   );

   sdm_lane #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_lane_left (
      .clock      (clock),
      .step       (step),
      .cfg        (cfg),
      .wr_pos     (wr_pos),
      .rd_pos     (rd_pos),
      .req_sample (req_data.left_in),
      .rsp_sample (left_res)
   );

   sdm_lane #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_lane_right (
      .clock      (clock),
      .step       (step),
      .cfg        (cfg),
      .wr_pos     (wr_pos),
      .rd_pos     (rd_pos),
      .req_sample (req_data.right_in),
      .rsp_sample (right_res)
   );

   // sequencer and merge of both lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new item in the output register wins over the one leaving it
         if (state_ff == S_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_PROD;
               end
            end
            S_PROD:   state_ff <= S_SUM;
            S_SUM:    state_ff <= S_MULMIX;
            S_MULMIX: state_ff <= S_MIX;
            S_MIX:    state_ff <= S_MULOUT;
            S_MULOUT: state_ff <= S_DONE;
            S_DONE: begin
               if (rsp_free) begin
                  rsp_data_ff.left_out  <= left_res;
                  rsp_data_ff.right_out <= right_res;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished item not moved to output register");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_free) |=> (state_ff == S_DONE && rsp_valid))
      else $error("finished item dropped while output stalled");
`endif

endmodule

// ----- tb/stereo_delay_with_ping_and_mix_unit_test.sv -----
`timescale 1ns / 1ps

module stereo_delay_with_ping_and_mix_unit_test;
   import sdm_pkg::*;

   localparam int     DEPTH          = 32768;
   localparam int     RANDOM_ITEMS   = 500;
   localparam int     HOLD_CYCLES    = 300;   // long output stall, forces input back-pressure
   localparam int     SETTLE_CYCLES  = 10;    // idle margin after the last awaited output drains
   localparam int     TIMEOUT_CYCLES = 200000;
   localparam longint SAMPLE_MAX     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_MIN     = -SAMPLE_MAX - 1;
   localparam logic [SAMPLE_BITS-1:0] S_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_BITS-1:0] S_MIN = 24'h800000;

   // directed plan: either a register write or one item, with an optional
   // hand-typed result where it is obvious
   typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_type;
   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    value;
      req_item_type             item;
      bit                       typed;
      rsp_item_type             want;
   } plan_row_type;

   // ---------------------------------------------------------------------
   // DUT connections; every input driven to a known value from time zero
   // ---------------------------------------------------------------------
   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_item_type            req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_item_type            rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   stereo_delay_with_ping_and_mix_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: register mirror, delay lines, write pointer, ping timer
   // ---------------------------------------------------------------------
   logic [LATENCY_W-1:0]          cfg_latency;
   logic                          cfg_ping_on;
   logic [INTERVAL_W-1:0]         cfg_interval;
   logic [LEVEL_W-1:0]            cfg_level;
   logic [MIX_W-1:0]              cfg_mix;
   logic [GAIN_W-1:0]             cfg_in_gain;
   logic [GAIN_W-1:0]             cfg_out_gain;
   logic                          cfg_bypass;
   logic signed [SAMPLE_BITS-1:0] line_left  [DEPTH];
   logic signed [SAMPLE_BITS-1:0] line_right [DEPTH];
   logic [LATENCY_W-1:0]          wr_pos;
   logic [INTERVAL_W-1:0]         ping_count;

   rsp_item_type awaited_outputs[$];   // predicted outputs, oldest first
   plan_row_type plan[$];
   logic [CSR_INDEX_W-1:0] batch_index[$];
   logic [CSR_DATA_W-1:0]  batch_value[$];

   bit quiet             = 1'b0;   // no idling on either side this phase
   bit hold_off_request  = 1'b0;   // ask the output side for one long stall
   int items_sent        = 0;
   int writes_done       = 0;
   int outputs_checked   = 0;
   int mismatches        = 0;
   int input_stalled     = 0;

   // round(v / 4096), ties toward +inf == floor((v + 2048) / 4096)
   function automatic longint round_q12(input longint v);
      return (v + 2048) >>> 12;
   endfunction

   function automatic longint clip24(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // interval 0 behaves as 1
   function automatic logic [INTERVAL_W-1:0] live_interval();
      return (cfg_interval == '0) ? INTERVAL_W'(1) : cfg_interval;
   endfunction

   function automatic void flush_delay_line();
      foreach (line_left[i]) begin
         line_left[i]  = '0;
         line_right[i] = '0;
      end
      wr_pos = '0;
   endfunction

   // dry/wet blend then output trim; 4092 and up is wet only
   function automatic longint mix_trim(input longint wet, input longint dry);
      longint m, a;
      if (cfg_mix >= MIX_WET_ONLY) begin
         m = wet;
      end else begin
         a = longint'(cfg_mix);
         m = clip24(round_q12(wet * a + dry * (longint'(Q12_ONE) - a)));
      end
      return clip24(round_q12(m * longint'(cfg_out_gain)));
   endfunction

   // one stereo pair through the delay path; advances predictor state
   function automatic rsp_item_type predict_output(input req_item_type s);
      longint lin, rin, ping, ldry, rdry, lsum, rsum, lwet, rwet, lout, rout;
      logic [LATENCY_W-1:0] rd_pos;
      rsp_item_type r;
      lin = $signed(s.left_in);
      rin = $signed(s.right_in);
      if (cfg_bypass) begin
         // straight through, line and ping timer frozen
         r.left_out  = s.left_in;
         r.right_out = s.right_in;
         return r;
      end
      ping = 0;
      if (cfg_ping_on) begin
         if (ping_count == '0) begin
            ping_count = live_interval();
            ping = longint'(cfg_level);
         end
         ping_count = ping_count - 1'b1;
      end else begin
         ping_count = live_interval();
      end
      ldry = clip24(round_q12(lin * longint'(cfg_in_gain)));
      rdry = clip24(round_q12(rin * longint'(cfg_in_gain)));
      lsum = clip24(ldry + ping);
      rsum = clip24(rdry + ping);
      if (cfg_latency == '0) begin
         lwet = lsum;
         rwet = rsum;
      end else begin
         rd_pos = wr_pos - cfg_latency;   // depth is 2^15, wraps by itself
         lwet = line_left[rd_pos];
         rwet = line_right[rd_pos];
         line_left[wr_pos]  = lsum[SAMPLE_BITS-1:0];
         line_right[wr_pos] = rsum[SAMPLE_BITS-1:0];
         wr_pos = wr_pos + 1'b1;
      end
      lout = mix_trim(lwet, ldry);
      rout = mix_trim(rwet, rdry);
      r.left_out  = lout[SAMPLE_BITS-1:0];
      r.right_out = rout[SAMPLE_BITS-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed plan builders
   // ---------------------------------------------------------------------
   function automatic void add_write(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      plan_row_type r;
      r = '0;
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.value = val;
      plan.insert(plan.size(), r);
   endfunction

   function automatic void add_item(input logic [SAMPLE_BITS-1:0] l,
                                    input logic [SAMPLE_BITS-1:0] rt);
      plan_row_type r;
      r = '0;
      r.kind          = ROW_ITEM;
      r.item.left_in  = l;
      r.item.right_in = rt;
      plan.insert(plan.size(), r);
   endfunction

   function automatic void add_fixed(input logic [SAMPLE_BITS-1:0] l,
                                     input logic [SAMPLE_BITS-1:0] rt,
                                     input logic [SAMPLE_BITS-1:0] el,
                                     input logic [SAMPLE_BITS-1:0] er);
      plan_row_type r;
      r = '0;
      r.kind           = ROW_ITEM;
      r.item.left_in   = l;
      r.item.right_in  = rt;
      r.typed          = 1'b1;
      r.want.left_out  = el;
      r.want.right_out = er;
      plan.insert(plan.size(), r);
   endfunction

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return SAMPLE_BITS'($urandom_range(0, 64) - 32);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // a setting for one register; 'extreme' picks the top of each range (mix just below wet only, bypass off).
   // Bits above the field are sometimes set, the block must drop them.
   function automatic logic [CSR_DATA_W-1:0] pick_setting(input logic [CSR_INDEX_W-1:0] idx,
                                                          input bit extreme);
      logic [CSR_DATA_W-1:0] v, junk;
      int width;
      v = '0;
      width = CSR_DATA_W;
      case (idx)
         REG_LATENCY: begin
            width = LATENCY_W;
            case ($urandom_range(0, 7))
               0:       v = 0;
               1:       v = {LATENCY_W{1'b1}};
               2:       v = 1;
               default: v = CSR_DATA_W'($urandom_range(2, 40));
            endcase
            if (extreme) v = {LATENCY_W{1'b1}};
         end
         REG_PING_ENABLE: begin
            width = 1;
            v = extreme ? 1 : CSR_DATA_W'($urandom_range(0, 1));
         end
         REG_PING_INTVL: begin
            width = INTERVAL_W;
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = 1;
               2:       v = {INTERVAL_W{1'b1}};
               3:       v = CSR_DATA_W'($urandom_range(0, (1 << INTERVAL_W) - 1));
               default: v = CSR_DATA_W'($urandom_range(2, 25));
            endcase
            if (extreme) v = {INTERVAL_W{1'b1}};
         end
         REG_PING_LEVEL: begin
            width = LEVEL_W;
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = {LEVEL_W{1'b1}};
               default: v = CSR_DATA_W'($urandom_range(0, (1 << LEVEL_W) - 1));
            endcase
            if (extreme) v = {LEVEL_W{1'b1}};
         end
         REG_MIX_AMOUNT: begin
            width = MIX_W;
            case ($urandom_range(0, 7))
               0:       v = 0;
               1:       v = MIX_WET_ONLY - 1;
               2:       v = MIX_WET_ONLY;
               3:       v = Q12_ONE;
               4:       v = CSR_DATA_W'($urandom_range(Q12_ONE + 1, (1 << MIX_W) - 1));
               default: v = CSR_DATA_W'($urandom_range(0, Q12_ONE));
            endcase
            if (extreme) v = MIX_WET_ONLY - 1;
         end
         REG_INPUT_GAIN, REG_OUTPUT_GAIN: begin
            width = GAIN_W;
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = {GAIN_W{1'b1}};
               2:       v = RST_GAIN;
               default: v = CSR_DATA_W'($urandom_range(1024, 8192));
            endcase
            if (extreme) v = {GAIN_W{1'b1}};
         end
         REG_BYPASS: begin
            width = 1;
            v = (!extreme && $urandom_range(0, 7) == 0) ? 1 : 0;
         end
         default: v = '0;
      endcase
      junk = CSR_DATA_W'($urandom());
      junk = junk << width;
      if ($urandom_range(0, 3) == 0) v = v | junk;
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // drop valid and let every awaited output drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid is left high after the write unless this is the last of a batch,
   // so back-to-back writes never lower and raise it in the same step
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (last) csr_valid <= 1'b0;
      writes_done++;
      case (idx)
         REG_LATENCY: begin
            cfg_latency = val[LATENCY_W-1:0];
            flush_delay_line();
         end
         REG_PING_ENABLE: cfg_ping_on = val[0];
         REG_PING_INTVL: begin
            cfg_interval = val[INTERVAL_W-1:0];
            if (ping_count > live_interval()) ping_count = live_interval();
         end
         REG_PING_LEVEL:  cfg_level    = val[LEVEL_W-1:0];
         REG_MIX_AMOUNT:  cfg_mix      = val[MIX_W-1:0];
         REG_INPUT_GAIN:  cfg_in_gain  = val[GAIN_W-1:0];
         REG_OUTPUT_GAIN: cfg_out_gain = val[GAIN_W-1:0];
         REG_BYPASS:      cfg_bypass   = val[0];
         default: ;
      endcase
   endtask

   // one item; valid stays high on return so a zero gap keeps it up
   task automatic send_item(input req_item_type s, input bit typed, input rsp_item_type want);
      int gap;
      rsp_item_type got;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_output(s);
      awaited_outputs.insert(awaited_outputs.size(), typed ? want : got);
      items_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Output side: random stall per item, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : output_drain
      int gap;
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 19);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Checker: every accepted output against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : output_check
      rsp_item_type want;
      if (!reset && req_valid && req_stall) input_stalled++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outputs.size() == 0) begin
            $display("%0t: output with nothing awaited, got left %0d right %0d",
                     $time, $signed(rsp_data.left_out), $signed(rsp_data.right_out));
            mismatches++;
         end else begin
            want = awaited_outputs.pop_front();
            outputs_checked++;
            if (rsp_data.left_out !== want.left_out) begin
               $display("%0t: left_out expected %0d, got %0d", $time,
                        $signed(want.left_out), $signed(rsp_data.left_out));
               mismatches++;
            end
            if (rsp_data.right_out !== want.right_out) begin
               $display("%0t: right_out expected %0d, got %0d", $time,
                        $signed(want.right_out), $signed(rsp_data.right_out));
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_item_type s;
      int directed_items, goal, phase, count, k, r;
      bit all_regs;

      // predictor in its reset state
      cfg_latency  = RST_LATENCY;
      cfg_ping_on  = 1'b0;
      cfg_interval = RST_INTERVAL;
      cfg_level    = RST_LEVEL;
      cfg_mix      = RST_MIX;
      cfg_in_gain  = RST_GAIN;
      cfg_out_gain = RST_GAIN;
      cfg_bypass   = 1'b0;
      ping_count   = RST_INTERVAL;
      flush_delay_line();

      // out of reset: 480-sample delay over a clear line, wet only -> silence
      add_fixed(S_MAX, S_MIN, 0, 0);
      add_fixed(S_MIN, S_MAX, 0, 0);
      add_fixed(24'h000000, 24'hFFFFFF, 0, 0);
      add_fixed(24'h555555, 24'hAAAAAA, 0, 0);
      // bypass: straight through
      add_write(REG_BYPASS, 1);
      add_fixed(S_MAX, S_MIN, S_MAX, S_MIN);
      add_fixed(24'h123456, 24'hFEDCBA, 24'h123456, 24'hFEDCBA);
      // zero latency with unity gains: straight pass through the math
      add_write(REG_BYPASS, 0);
      add_write(REG_LATENCY, 0);
      add_fixed(S_MAX, S_MIN, S_MAX, S_MIN);
      add_fixed(24'h000001, 24'hFFFFFF, 24'h000001, 24'hFFFFFF);
      // output trim at both ends
      add_write(REG_OUTPUT_GAIN, {GAIN_W{1'b1}});
      add_fixed(S_MAX, S_MIN, S_MAX, S_MIN);
      add_item(24'h000001, 24'hFFFFFF);
      add_write(REG_OUTPUT_GAIN, 0);
      add_fixed(S_MAX, S_MIN, 0, 0);
      // input trim at both ends, full dry mix
      add_write(REG_OUTPUT_GAIN, RST_GAIN);
      add_write(REG_INPUT_GAIN, 0);
      add_fixed(S_MAX, S_MIN, 0, 0);
      add_write(REG_INPUT_GAIN, {GAIN_W{1'b1}});
      add_write(REG_MIX_AMOUNT, 0);
      add_fixed(S_MAX, S_MIN, S_MAX, S_MIN);
      // ping with a zero interval (acts as one), full-scale level
      add_write(REG_INPUT_GAIN, RST_GAIN);
      add_write(REG_MIX_AMOUNT, RST_MIX);
      add_write(REG_PING_LEVEL, {LEVEL_W{1'b1}});
      add_write(REG_PING_INTVL, 0);
      add_write(REG_PING_ENABLE, 1);
      add_item(24'h000000, 24'h000000);
      add_item(24'h000000, 24'h000000);
      add_item(S_MIN, S_MAX);
      // short interval, countdown clamp
      add_write(REG_PING_INTVL, 3);
      add_write(REG_PING_LEVEL, 23'h400000);
      add_item(24'h100000, 24'hF00000);
      add_item(24'h3FFFFF, 24'hC00000);
      add_item(24'h000123, 24'hFFFEDC);
      // real delay with half mix
      add_write(REG_LATENCY, 3);
      add_write(REG_MIX_AMOUNT, 2048);
      add_item(24'h200000, 24'hE00000);
      add_item(24'h7FF000, 24'h801000);
      add_item(24'h000FFF, 24'hFFF001);
      // mix edges: just below wet only, wet only, above unity
      add_write(REG_MIX_AMOUNT, MIX_WET_ONLY - 1);
      add_item(24'h456789, 24'hBA9877);
      add_write(REG_MIX_AMOUNT, MIX_WET_ONLY);
      add_item(24'h0F0F0F, 24'hF0F0F1);
      add_write(REG_MIX_AMOUNT, {MIX_W{1'b1}});
      add_item(24'h700000, 24'h900000);

      while (reset) @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            if (i == 0 || plan[i-1].kind != ROW_WRITE) wait_idle();
            write_reg(plan[i].index, plan[i].value,
                      i + 1 == plan.size() || plan[i+1].kind != ROW_WRITE);
         end else begin
            send_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end
      directed_items = items_sent;

      // random phases: fresh settings on a subset of registers, then a burst.
      // Phase 0 writes everything, phase 1 everything at its extreme,
      // phase 3 runs flat out while the output side holds off.
      goal  = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < goal) begin
         wait_idle();
         batch_index.delete();
         batch_value.delete();
         all_regs = (phase <= 1);
         for (r = 0; r < 8; r++) begin
            if (all_regs || CSR_INDEX_W'(r) == REG_BYPASS || $urandom_range(0, 1) == 1) begin
               batch_index.insert(batch_index.size(), CSR_INDEX_W'(r));
               batch_value.insert(batch_value.size(),
                                  pick_setting(CSR_INDEX_W'(r), phase == 1));
            end
         end
         for (k = 0; k < batch_index.size(); k++)
            write_reg(batch_index[k], batch_value[k], k + 1 == batch_index.size());
         quiet = ($urandom_range(0, 3) == 0);
         count = $urandom_range(20, 60);
         if (phase == 3) begin
            quiet = 1'b1;
            hold_off_request = 1'b1;
            count = 60;
         end
         repeat (count) begin
            s.left_in  = pick_sample();
            s.right_in = pick_sample();
            send_item(s, 1'b0, '0);
         end
         phase++;
      end
      quiet = 1'b0;
      wait_idle();

      $display("Covered %0d items (%0d directed) over %0d random phases, %0d register writes.",
               items_sent, directed_items, phase, writes_done);
      $display("Checked %0d outputs, %0d mismatches, input held off for %0d cycles.",
               outputs_checked, mismatches, input_stalled);
      if (mismatches == 0) begin
         $display("[stereo_delay_with_ping_and_mix_unit] OK");
      end else begin
         $display("[stereo_delay_with_ping_and_mix_unit] ERROR");
      end
      $finish;
   end

   // hard stop if the handshakes ever hang
   initial begin : watchdog
      #(2 * TIMEOUT_CYCLES);
      $display("[stereo_delay_with_ping_and_mix_unit] ERROR");
      $finish;
   end

endmodule
